### src/utfv_pkg.sv
package utfv_pkg;

  localparam logic [7:0] ContMask = 8'hC0;
  localparam logic [7:0] ContTag  = 8'h80;
  localparam logic [7:0] Lead2Lo  = 8'hC2;
  localparam logic [7:0] Lead2Hi  = 8'hDF;
  localparam logic [7:0] Lead3Lo  = 8'hE0;
  localparam logic [7:0] Lead3Hi  = 8'hEF;
  localparam logic [7:0] Lead4Lo  = 8'hF0;
  localparam logic [7:0] Lead4Hi  = 8'hF4;
  localparam logic [7:0] LeadEd   = 8'hED;
  localparam logic [7:0] Cont1A0  = 8'hA0;
  localparam logic [7:0] Cont190  = 8'h90;

  localparam logic [2:0] SeqNone  = 3'd0;
  localparam logic [2:0] SeqTwo   = 3'd2;
  localparam logic [2:0] SeqThree = 3'd3;
  localparam logic [2:0] SeqFour  = 3'd4;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic       failed;
    logic [1:0] bytes_left;
    logic [2:0] seq_length;
    logic [7:0] lead_held;
    logic       first_cont_seen;
    logic       pending_bad;
  } utfv_state_t;

  localparam utfv_state_t StateReset = '{
    failed:          1'b0,
    bytes_left:      2'd0,
    seq_length:      SeqNone,
    lead_held:       8'h00,
    first_cont_seen: 1'b0,
    pending_bad:     1'b0
  };

endpackage

### src/utf8_stream_validator.sv
// UTF-8 window checker.
// Input channel: in_valid/in_ready carry one byte (data_byte) per item, with
// last_byte set on the final byte of a window. Output channel:
// out_valid/out_ready carry one item (is_valid) per window, sent after the
// flagged byte; bytes without the flag produce nothing.
// Each accepted byte lands in an input register; from that register the
// sequence checker updates its state, and on a flagged byte the verdict
// is written into a two-entry output queue. out_valid rises once that
// verdict is in the queue: a flagged byte passes the input register and
// then the queue entry before the receiver can take its verdict.
// Throughput is one byte per cycle while the queue has room for verdicts.
// When the receiver stalls, the queue absorbs up to two verdicts; a flagged
// byte then waits in the input register and in_ready falls only once that
// register is held. Bytes without the flag never wait on the queue itself.
// Reset (rst, synchronous) empties the input register and the queue and
// returns the checker to the start of a fresh window; the block is ready
// for a byte as soon as reset is released.
module utf8_stream_validator
  import utfv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       is_valid
);

  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        hold_last;
  logic        fire;
  logic        q_full;
  utfv_state_t state;
  utfv_state_t state_next;
  logic        verdict;

  assign fire     = hold_valid && (!hold_last || !q_full);
  assign in_ready = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= data_byte;
      hold_last <= last_byte;
    end
  end

  utfv_step u_step (
    .state      (state),
    .data_byte  (hold_byte),
    .last_byte  (hold_last),
    .state_next (state_next),
    .is_valid   (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StateReset;
    end else if (fire) begin
      state <= state_next;
    end
  end

  utfv_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fire && hold_last),
    .push_data (verdict),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (is_valid)
  );

  // a verdict is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (fire && hold_last) |-> !q_full)
    else $error("verdict pushed into full queue");

  // a flagged byte leaves the checker at the start of a fresh window
  a_window_clear: assert property (@(posedge clk) disable iff (rst)
    (fire && hold_last) |=> (state == StateReset))
    else $error("state not cleared after window end");

  // an open sequence always records its lead length
  a_seq_consistent: assert property (@(posedge clk) disable iff (rst)
    (state.bytes_left != 2'd0) |-> (state.seq_length != SeqNone))
    else $error("continuation due without an open sequence");

  // once failed, hold the state until the window ends
  a_failed_quiet: assert property (@(posedge clk) disable iff (rst)
    (fire && !hold_last && state.failed) |=> $stable(state))
    else $error("state moved after failure");

endmodule

### src/utfv_step.sv
module utfv_step
  import utfv_pkg::*;
(
  input  utfv_state_t state,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output utfv_state_t state_next,
  output logic        is_valid
);

  utfv_state_t s;
  logic        bad;

  always_comb begin
    s   = state;
    bad = state.pending_bad;
    if (!state.failed) begin
      if (state.bytes_left == 2'd0) begin
        // lead position
        if (data_byte >= ContTag) begin
          if (data_byte >= Lead2Lo && data_byte <= Lead2Hi) begin
            s.seq_length = SeqTwo;
            s.bytes_left = 2'd1;
          end else if (data_byte >= Lead3Lo && data_byte <= Lead3Hi) begin
            s.seq_length = SeqThree;
            s.bytes_left = 2'd2;
          end else if (data_byte >= Lead4Lo && data_byte <= Lead4Hi) begin
            s.seq_length = SeqFour;
            s.bytes_left = 2'd3;
          end else begin
            s.failed = 1'b1;
          end
          if (!s.failed) begin
            s.lead_held       = data_byte;
            s.first_cont_seen = 1'b0;
            s.pending_bad     = 1'b0;
          end
        end
      end else begin
        if ((data_byte & ContMask) != ContTag) bad = 1'b1;
        if (!state.first_cont_seen) begin
          // range limits on the first continuation byte
          if (state.seq_length == SeqThree && state.lead_held == Lead3Lo
              && data_byte < Cont1A0) bad = 1'b1;
          if (state.seq_length == SeqThree && state.lead_held == LeadEd
              && data_byte >= Cont1A0) bad = 1'b1;
          if (state.seq_length == SeqFour && state.lead_held == Lead4Lo
              && data_byte < Cont190) bad = 1'b1;
          if (state.seq_length == SeqFour && state.lead_held == Lead4Hi
              && data_byte >= Cont190) bad = 1'b1;
          s.first_cont_seen = 1'b1;
        end
        s.pending_bad = bad;
        s.bytes_left  = state.bytes_left - 2'd1;
        if (s.bytes_left == 2'd0) begin
          // sequence complete: commit any fault
          if (bad) s.failed = 1'b1;
          s.seq_length      = SeqNone;
          s.lead_held       = 8'h00;
          s.first_cont_seen = 1'b0;
          s.pending_bad     = 1'b0;
        end
      end
    end
    is_valid = !s.failed;
    if (last_byte) begin
      state_next = StateReset;
    end else begin
      state_next = s;
    end
  end

endmodule

### src/utfv_out_queue.sv
module utfv_out_queue
  import utfv_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic push_data,
  output logic full,
  output logic out_valid,
  input  logic out_ready,
  output logic out_data
);

  logic [QueueDepth-1:0] entry;
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  logic                  pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'(QueueDepth));
  assign out_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

endmodule
